[rtl/core/assert_macros.svh]
// Assertion macros shared by the great-circle distance RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define HVD_ASSERT(name, clock, reset, prop) \
  name: assert property (@(posedge clock) disable iff (reset) (prop)) \
    else $error("%m: assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define HVD_ASSERT_NEXT(name, clock, reset, pre, post) \
  name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
    else $error("%m: assertion failed");

`endif

[rtl/core/hvd_pkg.sv]
// Shared constants for the great-circle distance pipeline.
// Depends on nothing; used by every module under rtl/core except hvd_isqrt.
package hvd_pkg;

  localparam int ROT_W = 34;
  localparam int CORDIC_STEPS = 32;

  localparam logic signed [ROT_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;
  localparam logic signed [32:0] HALF_TURN = 33'sd2147483648;
  localparam logic [30:0] Z_MAX = 31'd1073741824;

  localparam logic signed [31:0] ARC_TAB [CORDIC_STEPS] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
    32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
    32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
    32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
    32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051,
    32'sh00000029, 32'sh00000014, 32'sh0000000A, 32'sh00000005,
    32'sh00000003, 32'sh00000001, 32'sh00000001, 32'sh00000000
  };

  // 45 * 2^31 keeps the biased angle positive; its quotient shift is a whole turn.
  localparam logic [37:0] DIV_BIAS = 38'd96636764160;
  localparam logic [14:0] RECIP_45 = 15'd23302;
  localparam logic [5:0] DIVISOR_45 = 6'd45;

  localparam logic [60:0] A_ONE = 61'h1000000000000000;

  localparam logic [35:0] FOUR_PI_Q32 = 36'd53972150818;
  localparam logic [17:0] PI_HI = FOUR_PI_Q32[35:18];
  localparam logic [17:0] PI_LO = FOUR_PI_Q32[17:0];

  localparam logic [15:0] RADIUS_RESET = 16'd6371;

endpackage

[rtl/core/haversine_distance_core.sv]
// Great-circle distance pipeline, haversine formula in fixed point.
// Depends on hvd_pkg, hvd_phase, hvd_rotate, hvd_isqrt, hvd_vector, assert_macros.svh.
//
//   channel  dir  fields (lowest bit up)
//   s_axis   in   tdata: start_latitude 30, start_longitude 31, end_latitude 30,
//                 end_longitude 31, zero pad 6
//   m_axis   out  tdata: distance_km 34, zero pad 6
//   cfg      in   cfg_wr_data: sphere_radius_km 16, written while cfg_wr_en
//
// One item per cycle while the skid register is empty. The pipeline includes
// the 32-step CORDICs and the 31-step square roots.
// Reset clears valid bits and sets the radius to 6371.
// A stalled output fills the output register, then one skid register; the
// pipeline and s_axis_tready hold only while the skid register is full.
`include "assert_macros.svh"

module haversine_distance_core #(
  parameter int ANGLE_FRACTION_BITS = 22,
  parameter int DISTANCE_FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // start_latitude, start_longitude, end_latitude, end_longitude
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,   // distance_km
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data     // sphere_radius_km
);

  localparam int unsigned SHIFT_HALF = 28 - ANGLE_FRACTION_BITS;
  localparam int unsigned SHIFT_FULL = 29 - ANGLE_FRACTION_BITS;
  localparam int unsigned DIGITS = (38 + SHIFT_FULL + 7) / 8;
  localparam int RSH = 41 - DISTANCE_FRACTION_BITS;
  localparam logic [61:0] RND = 62'(1) << (40 - DISTANCE_FRACTION_BITS);

  logic [15:0] radius;
  logic        ce;
  logic        in_valid;

  logic signed [29:0] lat1;
  logic signed [30:0] lon1;
  logic signed [29:0] lat2;
  logic signed [30:0] lon2;
  logic signed [31:0] dlat;
  logic signed [31:0] dlon;

  logic [3:0]  ph_v;
  logic [31:0] ph [4];
  logic [3:0]  rot_v;
  logic signed [31:0] s_lat;
  logic signed [31:0] s_lon;
  logic signed [31:0] c1;
  logic signed [31:0] c2;

  logic [2:0]         mv;
  logic signed [63:0] p1;
  logic signed [63:0] p2;
  logic signed [63:0] sq;
  logic signed [63:0] uv;
  logic signed [63:0] sq2;
  logic signed [63:0] a_sum;
  logic [60:0]        a_next;
  logic [60:0]        a_cl;

  logic [1:0]  sq_v;
  logic [30:0] root_a;
  logic [30:0] root_b;
  logic        vec_v;
  logic [30:0] vec_z;

  logic [3:0]  fv;
  logic [46:0] m;
  logic [41:0] pa;
  logic [41:0] pb;
  logic [40:0] pc;
  logic [40:0] pd;
  logic [60:0] hi;
  logic [35:0] lo;
  logic [61:0] sum;
  logic [61:0] scaled;
  logic [33:0] dist_next;

  logic        o_v;
  logic [33:0] o_data;
  logic        sk_v;
  logic [33:0] sk_data;
  logic        take;
  logic        out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= hvd_pkg::RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  assign ce            = !sk_v;
  assign s_axis_tready = ce;
  assign in_valid      = s_axis_tvalid && ce;

  assign lat1 = signed'(s_axis_tdata[29:0]);
  assign lon1 = signed'(s_axis_tdata[60:30]);
  assign lat2 = signed'(s_axis_tdata[90:61]);
  assign lon2 = signed'(s_axis_tdata[121:91]);
  assign dlat = 32'(lat2) - 32'(lat1);
  assign dlon = 32'(lon2) - 32'(lon1);

  hvd_phase #(.SHIFT_BITS(SHIFT_HALF), .DIGITS(DIGITS)) u_ph_dlat (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(in_valid), .angle(dlat),
    .out_valid(ph_v[0]), .phase(ph[0])
  );
  hvd_phase #(.SHIFT_BITS(SHIFT_HALF), .DIGITS(DIGITS)) u_ph_dlon (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(in_valid), .angle(dlon),
    .out_valid(ph_v[1]), .phase(ph[1])
  );
  hvd_phase #(.SHIFT_BITS(SHIFT_FULL), .DIGITS(DIGITS)) u_ph_lat1 (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(in_valid), .angle(32'(lat1)),
    .out_valid(ph_v[2]), .phase(ph[2])
  );
  hvd_phase #(.SHIFT_BITS(SHIFT_FULL), .DIGITS(DIGITS)) u_ph_lat2 (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(in_valid), .angle(32'(lat2)),
    .out_valid(ph_v[3]), .phase(ph[3])
  );

  hvd_rotate u_rot_dlat (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(ph_v[0]), .phase(ph[0]),
    .out_valid(rot_v[0]), .cos_q(), .sin_q(s_lat)
  );
  hvd_rotate u_rot_dlon (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(ph_v[1]), .phase(ph[1]),
    .out_valid(rot_v[1]), .cos_q(), .sin_q(s_lon)
  );
  hvd_rotate u_rot_lat1 (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(ph_v[2]), .phase(ph[2]),
    .out_valid(rot_v[2]), .cos_q(c1), .sin_q()
  );
  hvd_rotate u_rot_lat2 (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(ph_v[3]), .phase(ph[3]),
    .out_valid(rot_v[3]), .cos_q(c2), .sin_q()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= '0;
    end else if (ce) begin
      mv <= {mv[1:0], rot_v[0]};
    end
  end

  always_comb begin
    a_sum = sq2 + uv;
    if (a_sum[63]) begin
      a_next = '0;
    end else if (a_sum > 64'(hvd_pkg::A_ONE)) begin
      a_next = hvd_pkg::A_ONE;
    end else begin
      a_next = 61'(a_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p1   <= 64'(s_lon) * 64'(c1);
      p2   <= 64'(s_lon) * 64'(c2);
      sq   <= 64'(s_lat) * 64'(s_lat);
      uv   <= 64'(signed'(p1[61:30])) * 64'(signed'(p2[61:30]));
      sq2  <= sq;
      a_cl <= a_next;
    end
  end

  hvd_isqrt u_sqrt_a (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(mv[2]), .value(a_cl),
    .out_valid(sq_v[0]), .root(root_a)
  );
  hvd_isqrt u_sqrt_b (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(mv[2]), .value(hvd_pkg::A_ONE - a_cl),
    .out_valid(sq_v[1]), .root(root_b)
  );

  hvd_vector u_vec (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(sq_v[0]), .x_in(root_b), .y_in(root_a),
    .out_valid(vec_v), .angle(vec_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (ce) begin
      fv <= {fv[2:0], vec_v};
    end
  end

  always_comb begin
    sum       = 62'(hi) + 62'(lo) + RND;
    scaled    = sum >> RSH;
    dist_next = (|scaled[61:34]) ? '1 : scaled[33:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m      <= 47'(radius) * 47'(vec_z);
      pa     <= 42'(m[46:23]) * 42'(hvd_pkg::PI_HI);
      pb     <= 42'(m[46:23]) * 42'(hvd_pkg::PI_LO);
      pc     <= 41'(m[22:0]) * 41'(hvd_pkg::PI_HI);
      pd     <= 41'(m[22:0]) * 41'(hvd_pkg::PI_LO);
      hi     <= (61'(pa) << 18) + 61'(pb);
      lo     <= 36'(((59'(pc) << 18) + 59'(pd)) >> 23);
    end
  end

  assign take     = ce && fv[3];
  assign out_fire = o_v && m_axis_tready;

  logic [33:0] dist_q;

  always_ff @(posedge clk) begin
    if (ce) begin
      dist_q <= dist_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v  <= 1'b0;
      sk_v <= 1'b0;
    end else if (sk_v) begin
      if (out_fire) begin
        sk_v <= 1'b0;
      end
    end else if (take && o_v && !out_fire) begin
      sk_v <= 1'b1;
    end else if (take) begin
      o_v <= 1'b1;
    end else if (out_fire) begin
      o_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v) begin
      if (out_fire) begin
        o_data <= sk_data;
      end
    end else if (take) begin
      if (!o_v || out_fire) begin
        o_data <= dist_q;
      end else begin
        sk_data <= dist_q;
      end
    end
  end

  assign m_axis_tvalid = o_v;
  assign m_axis_tdata  = {6'b0, o_data};

  `HVD_ASSERT(a_rot_aligned, clk, rst, (&rot_v) == (|rot_v))
  `HVD_ASSERT(a_sqrt_aligned, clk, rst, sq_v[0] == sq_v[1])
  `HVD_ASSERT(a_skid_behind_out, clk, rst, !sk_v || o_v)
  `HVD_ASSERT_NEXT(a_stall_to_skid, clk, rst, take && o_v && !m_axis_tready, sk_v)
  `HVD_ASSERT(a_angle_range, clk, rst, !vec_v || vec_z <= hvd_pkg::Z_MAX)

endmodule

[rtl/core/hvd_phase.sv]
// Angle to 32-bit phase: floor(angle * 2^SHIFT_BITS / 45) mod 2^32.
// Byte-wise long division by 45, one byte per stage. Depends on hvd_pkg.
module hvd_phase #(
  parameter int unsigned SHIFT_BITS = 6,
  parameter int unsigned DIGITS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_valid,
  input  logic signed [31:0] angle,
  output logic               out_valid,
  output logic [31:0]        phase
);

  localparam int unsigned PW = DIGITS * 8;

  logic [37:0]   biased;
  logic [DIGITS:0] vl;
  logic [PW-1:0] dv [DIGITS+1];
  logic [5:0]    rm [DIGITS+1];
  logic [31:0]   qt [DIGITS+1];

  assign biased = 38'(angle) + hvd_pkg::DIV_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (ce) begin
      vl <= {vl[DIGITS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dv[0] <= PW'(biased) << SHIFT_BITS;
      rm[0] <= '0;
      qt[0] <= '0;
    end
  end

  for (genvar j = 0; j < DIGITS; j++) begin : g_digit
    logic [13:0] num;
    logic [28:0] prod;
    logic [7:0]  qd;
    logic [5:0]  rn;

    assign num  = {rm[j], dv[j][PW-1-8*j -: 8]};
    assign prod = 29'(num) * 29'(hvd_pkg::RECIP_45);
    assign qd   = prod[27:20];
    assign rn   = 6'(num - 14'(qd) * 14'(hvd_pkg::DIVISOR_45));

    always_ff @(posedge clk) begin
      if (ce) begin
        dv[j+1] <= dv[j];
        rm[j+1] <= rn;
        qt[j+1] <= {qt[j][23:0], qd};
      end
    end
  end

  assign out_valid = vl[DIGITS];
  assign phase     = qt[DIGITS];

endmodule

[rtl/core/hvd_rotate.sv]
// Rotation CORDIC: cosine and sine in Q30 of a 32-bit phase, one step per stage.
// Folds the phase into a quarter turn first. Depends on hvd_pkg.
module hvd_rotate (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_valid,
  input  logic [31:0]        phase,
  output logic               out_valid,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  localparam int N  = hvd_pkg::CORDIC_STEPS;
  localparam int RW = hvd_pkg::ROT_W;

  logic [N+1:0]          vl;
  logic                  ng [N+1];
  logic signed [RW-1:0]  xr [N+1];
  logic signed [RW-1:0]  yr [N+1];
  logic signed [31:0]    zr [N+1];
  logic signed [32:0]    z_wide;
  logic signed [32:0]    z_fold;
  logic                  neg_fold;

  always_comb begin
    z_wide   = 33'(signed'(phase));
    z_fold   = z_wide;
    neg_fold = 1'b0;
    if (z_wide > hvd_pkg::QUARTER_TURN) begin
      z_fold   = z_wide - hvd_pkg::HALF_TURN;
      neg_fold = 1'b1;
    end else if (z_wide < -hvd_pkg::QUARTER_TURN) begin
      z_fold   = z_wide + hvd_pkg::HALF_TURN;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (ce) begin
      vl <= {vl[N:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      zr[0] <= 32'(z_fold);
      xr[0] <= hvd_pkg::GAIN_Q30;
      yr[0] <= '0;
      ng[0] <= neg_fold;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [RW-1:0] dx;
    logic signed [RW-1:0] dy;

    assign dx = yr[i] >>> i;
    assign dy = xr[i] >>> i;

    always_ff @(posedge clk) begin
      if (ce) begin
        ng[i+1] <= ng[i];
        if (!zr[i][31]) begin
          xr[i+1] <= xr[i] - dx;
          yr[i+1] <= yr[i] + dy;
          zr[i+1] <= zr[i] - hvd_pkg::ARC_TAB[i];
        end else begin
          xr[i+1] <= xr[i] + dx;
          yr[i+1] <= yr[i] - dy;
          zr[i+1] <= zr[i] + hvd_pkg::ARC_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cos_q <= ng[N] ? 32'(-xr[N]) : 32'(xr[N]);
      sin_q <= ng[N] ? 32'(-yr[N]) : 32'(yr[N]);
    end
  end

  assign out_valid = vl[N+1];

endmodule

[rtl/core/hvd_isqrt.sv]
// Floor integer square root of a 61-bit value, one result bit per stage.
// Depends on nothing but its ports.
module hvd_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        ce,
  input  logic        in_valid,
  input  logic [60:0] value,
  output logic        out_valid,
  output logic [30:0] root
);

  localparam int N = 31;

  logic [N:0]  vl;
  logic [60:0] rv [N+1];
  logic [60:0] rs [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (ce) begin
      vl <= {vl[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rv[0] <= value;
      rs[0] <= '0;
    end
  end

  for (genvar t = 0; t < N; t++) begin : g_step
    localparam logic [60:0] BIT = 61'(1) << (60 - 2 * t);
    logic [60:0] trial;

    assign trial = rs[t] + BIT;

    always_ff @(posedge clk) begin
      if (ce) begin
        if (rv[t] >= trial) begin
          rv[t+1] <= rv[t] - trial;
          rs[t+1] <= (rs[t] >> 1) + BIT;
        end else begin
          rv[t+1] <= rv[t];
          rs[t+1] <= rs[t] >> 1;
        end
      end
    end
  end

  assign out_valid = vl[N];
  assign root      = rs[N][30:0];

endmodule

[rtl/core/hvd_vector.sv]
// Vectoring CORDIC: phase of (x, y) in 2^32 per turn, clamped to [0, quarter].
// One step per stage. Depends on hvd_pkg.
module hvd_vector (
  input  logic        clk,
  input  logic        rst,
  input  logic        ce,
  input  logic        in_valid,
  input  logic [30:0] x_in,
  input  logic [30:0] y_in,
  output logic        out_valid,
  output logic [30:0] angle
);

  localparam int N = hvd_pkg::CORDIC_STEPS;

  logic [N+1:0]       vl;
  logic signed [32:0] xr [N+1];
  logic signed [32:0] yr [N+1];
  logic signed [31:0] zr [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (ce) begin
      vl <= {vl[N:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xr[0] <= signed'({2'b00, x_in});
      yr[0] <= signed'({2'b00, y_in});
      zr[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               pos;

    assign dx  = yr[i] >>> i;
    assign dy  = xr[i] >>> i;
    assign pos = !yr[i][32] && (yr[i] != '0);

    always_ff @(posedge clk) begin
      if (ce) begin
        if (pos) begin
          xr[i+1] <= xr[i] + dx;
          yr[i+1] <= yr[i] - dy;
          zr[i+1] <= zr[i] + hvd_pkg::ARC_TAB[i];
        end else begin
          xr[i+1] <= xr[i] - dx;
          yr[i+1] <= yr[i] + dy;
          zr[i+1] <= zr[i] - hvd_pkg::ARC_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (zr[N][31]) begin
        angle <= '0;
      end else if (zr[N] > 32'(hvd_pkg::Z_MAX)) begin
        angle <= hvd_pkg::Z_MAX;
      end else begin
        angle <= zr[N][30:0];
      end
    end
  end

  assign out_valid = vl[N+1];

endmodule
